FILE: design/est_pkg.sv
package est_pkg;

   localparam int MAX_SLOTS     = 32;
   localparam int TILE_PIXELS_W = 16;
   localparam int TILE_PIXELS_H = 16;

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   localparam logic [2:0] OP_SPAWN  = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_CLEAR  = 3'd2;
   localparam logic [2:0] OP_LOCATE = 3'd3;
   localparam logic [2:0] OP_FIND   = 3'd4;
   localparam logic [2:0] OP_NONE   = 3'd7;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_NONE = 2'd2;

   typedef struct packed {
      logic [2:0]        op;
      logic [3:0]        entity_type;
      logic [7:0]        pos_x;
      logic [7:0]        pos_y;
      logic [7:0]        tiles_w;
      logic [7:0]        tiles_h;
      logic [SLOT_W-1:0] slot_index;
   } cmd_type;

   typedef struct packed {
      logic [3:0] entity_type;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] tiles_w;
      logic [7:0] tiles_h;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
      logic [3:0]        found_type;
   } result_type;

endpackage

FILE: design/est_ifs.sv
interface est_req_if;
   import est_pkg::*;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [3:0]  entity_type;
   logic [7:0]  pos_x;
   logic [7:0]  pos_y;
   logic [7:0]  sprite_width;
   logic [7:0]  sprite_height;
   logic [SLOT_W-1:0] slot_index;
   modport source (output valid, command, entity_type, pos_x, pos_y, sprite_width,
                   sprite_height, slot_index, input ready);
   modport sink (input valid, command, entity_type, pos_x, pos_y, sprite_width,
                 sprite_height, slot_index, output ready);
endinterface

interface est_rsp_if;
   import est_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [SLOT_W-1:0] slot;
   logic [3:0]        found_type;
   modport source (output valid, status, slot, found_type, input ready);
   modport sink (input valid, status, slot, found_type, output ready);
endinterface

interface est_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: design/est_ram.sv
module est_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/est_front.sv
module est_front (
   est_req_if.sink          req,
   output logic             push_valid,
   output est_pkg::cmd_type push_data,
   input  logic             push_ready
);
   import est_pkg::*;

   logic [8:0] w_sum;
   logic [8:0] h_sum;
   logic [7:0] w_tiles;
   logic [7:0] h_tiles;
   logic [2:0] op;

   // footprint: ceil(pixels / tile), at least one tile
   assign w_sum   = 9'(req.sprite_width) + 9'(TILE_PIXELS_W - 1);
   assign h_sum   = 9'(req.sprite_height) + 9'(TILE_PIXELS_H - 1);
   assign w_tiles = 8'(w_sum / TILE_PIXELS_W);
   assign h_tiles = 8'(h_sum / TILE_PIXELS_H);

   always_comb begin
      unique case (req.command)
         OP_SPAWN:  op = OP_SPAWN;
         OP_REMOVE: op = OP_REMOVE;
         OP_CLEAR:  op = OP_CLEAR;
         OP_LOCATE: op = OP_LOCATE;
         OP_FIND:   op = OP_FIND;
         default:   op = OP_NONE;
      endcase
   end

   always_comb begin
      push_data.op          = op;
      push_data.entity_type = req.entity_type;
      push_data.pos_x       = req.pos_x;
      push_data.pos_y       = req.pos_y;
      push_data.tiles_w     = (w_tiles == 8'd0) ? 8'd1 : w_tiles;
      push_data.tiles_h     = (h_tiles == 8'd0) ? 8'd1 : h_tiles;
      push_data.slot_index  = req.slot_index;
   end

   assign push_valid = req.valid;
   assign req.ready  = push_ready;
endmodule

FILE: design/est_queue.sv
module est_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  est_pkg::cmd_type push_data,
   output logic             push_ready,
   output logic             pop_valid,
   output est_pkg::cmd_type pop_data,
   input  logic             pop_ready
);
   import est_pkg::*;

   cmd_type         mem_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != Q_CW'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

FILE: design/est_back.sv
module est_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   input  est_pkg::cmd_type pop_data,
   output logic             pop_ready,
   est_csr_if.sink          csr,
   est_rsp_if.source        rsp
);
   import est_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]           state_ff, state_in;
   cmd_type              op_ff, op_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [SLOT_W-1:0]    chk_idx_ff, chk_idx_in;
   logic [MAX_SLOTS-1:0] active_ff, active_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   result_type           res_ff, res_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   result_type           rsp_ff, rsp_in;
   logic [3:0]           player_ff;

   logic              ram_we;
   logic [SLOT_W-1:0] ram_waddr;
   entry_type         ram_wdata;
   entry_type         ram_rdata;
   logic [ENTRY_W-1:0] ram_rbits;

   logic       hit;
   logic [8:0] x_end, y_end;
   logic       covers;
   logic       out_free;

   est_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cnt_ff[SLOT_W-1:0]),
      .rd_data (ram_rbits)
   );

   assign ram_rdata = entry_type'(ram_rbits);

   assign x_end  = 9'(ram_rdata.pos_x) + 9'(ram_rdata.tiles_w);
   assign y_end  = 9'(ram_rdata.pos_y) + 9'(ram_rdata.tiles_h);
   assign covers = (op_ff.pos_x >= ram_rdata.pos_x) && (9'(op_ff.pos_x) < x_end) &&
                   (op_ff.pos_y >= ram_rdata.pos_y) && (9'(op_ff.pos_y) < y_end);

   always_comb begin
      hit = 1'b0;
      if (chk_vld_ff) begin
         case (op_ff.op)
            OP_SPAWN:  hit = !active_ff[chk_idx_ff];
            OP_LOCATE: hit = active_ff[chk_idx_ff] && covers;
            OP_FIND:   hit = active_ff[chk_idx_ff] && (ram_rdata.entity_type == player_ff);
            default:   hit = 1'b0;
         endcase
      end
   end

   assign out_free  = !rsp_vld_ff || rsp.ready;
   assign pop_ready = (state_ff == ST_IDLE);

   assign ram_wdata.entity_type = op_ff.entity_type;
   assign ram_wdata.pos_x       = op_ff.pos_x;
   assign ram_wdata.pos_y       = op_ff.pos_y;
   assign ram_wdata.tiles_w     = op_ff.tiles_w;
   assign ram_wdata.tiles_h     = op_ff.tiles_h;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      cnt_in     = cnt_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      active_in  = active_ff;
      used_in    = used_ff;
      res_in     = res_ff;
      rsp_vld_in = rsp_vld_ff && !rsp.ready;
      rsp_in     = rsp_ff;
      ram_we     = 1'b0;
      ram_waddr  = chk_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               op_in      = pop_data;
               cnt_in     = '0;
               res_in     = '{status: STATUS_OK, slot: '0, found_type: '0};
               state_in   = ST_DONE;
               case (pop_data.op) inside
                  OP_SPAWN, OP_LOCATE, OP_FIND: state_in = ST_SCAN;
                  OP_REMOVE: begin
                     if (32'(pop_data.slot_index) < MAX_SLOTS) begin
                        active_in[pop_data.slot_index] = 1'b0;
                     end
                  end
                  OP_CLEAR: used_in = '0;
                  default:  res_in.status = STATUS_NONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               res_in.status     = STATUS_OK;
               res_in.slot       = chk_idx_ff;
               res_in.found_type = (op_ff.op == OP_LOCATE) ? ram_rdata.entity_type : 4'd0;
               if (op_ff.op == OP_SPAWN) begin
                  ram_we                = 1'b1;
                  active_in[chk_idx_ff] = 1'b1;
               end
               state_in = ST_DONE;
            end else if (cnt_ff < used_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = cnt_ff[SLOT_W-1:0];
               cnt_in     = cnt_ff + CNT_W'(1);
            end else begin
               state_in = ST_DONE;
               if (op_ff.op == OP_SPAWN) begin
                  if (used_ff < CNT_W'(MAX_SLOTS)) begin
                     ram_we     = 1'b1;
                     ram_waddr  = used_ff[SLOT_W-1:0];
                     active_in[used_ff[SLOT_W-1:0]] = 1'b1;
                     used_in    = used_ff + CNT_W'(1);
                     res_in.slot = used_ff[SLOT_W-1:0];
                  end else begin
                     res_in.status = STATUS_FULL;
                  end
               end else begin
                  res_in.status = STATUS_NONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               rsp_in     = res_ff;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         chk_vld_ff <= 1'b0;
         active_ff  <= '0;
         used_ff    <= '0;
         rsp_vld_ff <= 1'b0;
         player_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         active_ff  <= active_in;
         used_ff    <= used_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr.valid) begin
            player_ff <= csr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      cnt_ff     <= cnt_in;
      chk_idx_ff <= chk_idx_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign csr.ready      = 1'b1;
   assign rsp.valid      = rsp_vld_ff;
   assign rsp.status     = rsp_ff.status;
   assign rsp.slot       = rsp_ff.slot;
   assign rsp.found_type = rsp_ff.found_type;
endmodule

FILE: design/entity_slot_table_unit.sv
// Remove, clear and unknown commands go from idle straight to the done state;
// spawn, locate and find player scan the used slots first, one slot a cycle
// through the entry RAM's registered read port, before the done state.
// The back end takes a new request only when idle, once the last answer has left
// the done state; a two-entry queue takes requests ahead.
// Reset: clears flags, slot count, player code, queue, response valid; not entry RAM.
module entity_slot_table_unit (
   input  logic      clock,
   input  logic      reset,
   est_req_if.sink   req_port,
   est_csr_if.sink   csr_port,
   est_rsp_if.source rsp_port
);
   import est_pkg::*;

   logic    push_valid, push_ready;
   cmd_type push_data;
   logic    pop_valid, pop_ready;
   cmd_type pop_data;

   est_front u_front (
      .req        (req_port),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   est_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   est_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .csr       (csr_port),
      .rsp       (rsp_port)
   );
endmodule
